/* design/swamd_pkg.sv */
package swamd_pkg;

    // Fixed field and register geometry
    localparam int AXES            = 6;
    localparam int WIN_LEN_W       = 11;
    localparam int DISCARD_W       = 8;
    localparam int CFG_DATA_W      = 11;
    localparam int CFG_IDX_W       = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD    = 1'b1;

    // Register reset values
    localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST = 11'd100;
    localparam logic [DISCARD_W-1:0] DISCARD_RST    = 8'd11;

    // Default sizing
    localparam int MAX_WINDOW_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEN_W_DEF       = $clog2(MAX_WINDOW_DEF + 1);
    localparam int IDX_W_DEF       = $clog2(MAX_WINDOW_DEF + (1 << DISCARD_W));
    localparam int SUM_W_DEF       = SAMPLE_BITS_DEF + IDX_W_DEF;

endpackage

/* design/six_axis_window_mean_delta.sv */
// Six-axis window averager. Each input beat carries one motion sample (accel x/y/z,
// gyro x/y/z, signed). Every window first drops discard_count samples, then sums
// window_len samples per axis; the beat that closes the window produces one output
// beat with the six means (sum / window_len, truncated toward zero) and the absolute
// change of each mean from the previous window's mean (from zero for the first window).
// window_len of zero acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
// A beat that does not close a window is accepted while the block is idle. A closing beat
// starts six divisions on one shared restoring divider, one quotient bit per cycle,
// and the block accepts no sample until all six are done. Dividends are SUM_W =
// SAMPLE_BITS + clog2(MAX_WINDOW + 256) bits wide.
// The result waits in an output register; samples keep flowing meanwhile, and only
// the next closing beat is held off until that result has been taken.
// Write the configuration registers only while no result is being computed.
module six_axis_window_mean_delta
    import swamd_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // fields from bit 0: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [((AXES*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // fields from bit 0: mean_accel_x, mean_accel_y, mean_accel_z, mean_gyro_x,
    // mean_gyro_y, mean_gyro_z, change_accel_x, change_accel_y, change_accel_z,
    // change_gyro_x, change_gyro_y, change_gyro_z
    output logic [((2*AXES*SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W   = $clog2(MAX_WINDOW + (1 << DISCARD_W));
    localparam int CMP_W   = IDX_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + IDX_W;
    localparam int AXIS_W  = $clog2(AXES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [WIN_LEN_W-1:0]          r_win_len;
    logic [DISCARD_W-1:0]          r_discard;
    logic [IDX_W-1:0]              r_idx;
    logic signed [SUM_W-1:0]       r_sums [AXES];
    logic signed [SUM_W-1:0]       r_prev [AXES];
    logic [1:0]                    r_state;
    logic [AXIS_W-1:0]             r_axis;
    logic [LEN_W-1:0]              r_len;
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_mean [AXES];
    logic [SAMPLE_BITS-1:0]        r_chg  [AXES];

    logic [LEN_W-1:0]              w_eff_len;
    logic                          w_take;
    logic                          w_close;
    logic                          w_in_fire;
    logic signed [SAMPLE_BITS-1:0] w_smp [AXES];
    logic signed [SUM_W-1:0]       w_cur_sum;
    logic [SUM_W-1:0]              w_mag;
    logic                          w_div_done;
    logic [SUM_W-1:0]              w_quot;
    logic signed [SUM_W-1:0]       w_mean;
    logic signed [SUM_W:0]         w_diff;
    logic [SUM_W:0]                w_absd;

    // Clamp the window length into 1 .. MAX_WINDOW
    always_comb begin
        if (r_win_len == '0) begin
            w_eff_len = LEN_W'(1);
        end else if (32'(r_win_len) > 32'(MAX_WINDOW)) begin
            w_eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_eff_len = LEN_W'(r_win_len);
        end
    end

    // Sum once past the discard span; close when the window count is reached
    assign w_take  = r_idx >= IDX_W'(r_discard);
    assign w_close = (CMP_W'(r_idx) + CMP_W'(1)) >= (CMP_W'(r_discard) + CMP_W'(w_eff_len));

    // Hold off a closing beat while the previous result still waits
    assign o_s_axis_tready = (r_state == S_IDLE) && !(r_out_valid && w_close);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_smp[k] = $signed(i_s_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS]);
        end
    end

    // Divide magnitudes, restore the sign afterwards (truncation toward zero)
    assign w_cur_sum = r_sums[r_axis];
    assign w_mag     = w_cur_sum[SUM_W-1] ? SUM_W'(-w_cur_sum) : SUM_W'(w_cur_sum);

    swamd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (w_mag),
        .i_divisor  (r_len),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_mean = w_cur_sum[SUM_W-1] ? -$signed(w_quot) : $signed(w_quot);
    assign w_diff = (SUM_W+1)'(w_mean) - (SUM_W+1)'(r_prev[r_axis]);
    assign w_absd = w_diff[SUM_W] ? (SUM_W+1)'(-w_diff) : (SUM_W+1)'(w_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= WINDOW_LEN_RST;
            r_discard   <= DISCARD_RST;
            r_idx       <= '0;
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_sums[k] <= '0;
                r_prev[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WINDOW_LEN: r_win_len <= i_cfg_data[WIN_LEN_W-1:0];
                    REG_DISCARD:    r_discard <= i_cfg_data[DISCARD_W-1:0];
                    default:        ;
                endcase
            end

            // drop the result once the downstream beat completes
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (w_take) begin
                            for (int k = 0; k < AXES; k++) begin
                                r_sums[k] <= r_sums[k] + SUM_W'(w_smp[k]);
                            end
                        end
                        if (w_close) begin
                            r_idx   <= '0;
                            r_len   <= w_eff_len;
                            r_axis  <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_div_done) begin
                        r_prev[r_axis] <= w_mean;
                        r_sums[r_axis] <= '0;
                        if (r_axis == AXIS_W'(AXES - 1)) begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_axis  <= r_axis + AXIS_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Fill the output register one axis at a time; it is free while dividing
    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_div_done) begin
            r_mean[r_axis] <= w_mean[SAMPLE_BITS-1:0];
            r_chg[r_axis]  <= w_absd[SAMPLE_BITS-1:0];
        end
    end

    // len is only ever loaded before use; keep it out of reset with the payload
    always_comb begin
        o_m_axis_tdata = '0;
        for (int k = 0; k < AXES; k++) begin
            o_m_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS]        = r_mean[k];
            o_m_axis_tdata[(AXES+k)*SAMPLE_BITS +: SAMPLE_BITS] = r_chg[k];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

endmodule

/* design/swamd_div.sv */
module swamd_div
    import swamd_pkg::*;
#(
    parameter int DIVIDEND_W = SUM_W_DEF,
    parameter int DIVISOR_W  = LEN_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W+1:0]  w_diff;
    logic                  w_ge;

    // One restoring step: bring down the next dividend bit, try a subtract
    assign w_shift = {r_rem, r_quot[DIVIDEND_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_ge    = !w_diff[DIVISOR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quot <= {r_quot[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
